FILE: rtl/hfti_pkg.sv
`default_nettype none

package hfti_pkg;

   localparam int HALF_WIDTH = 16;
   localparam int INT_WIDTH  = 32;
   localparam int EXP_WIDTH  = 5;
   localparam int FRAC_WIDTH = 10;
   localparam int SIG_WIDTH  = FRAC_WIDTH + 1;
   localparam int BIAS       = 15;
   // binary point position of sig << exp_eff: BIAS + FRAC_WIDTH
   localparam int POINT      = BIAS + FRAC_WIDTH;
   // finite values stay below 2^16, so the integer part is 16 bits
   localparam int WHOLE_WIDTH = 16;
   localparam int MAG_WIDTH   = WHOLE_WIDTH + 1;
   localparam int ALIGN_WIDTH = POINT + WHOLE_WIDTH;

   localparam logic [EXP_WIDTH-1:0] EXP_ALL_ONES = 5'h1f;
   localparam logic [EXP_WIDTH-1:0] EXP_SUBNORMAL = 5'h01;
   localparam logic [INT_WIDTH-1:0] INVALID_RESULT = 32'h7fff_ffff;

   typedef enum logic [1:0] {
      RM_TOWARD_ZERO = 2'd0,
      RM_DOWNWARD    = 2'd1,
      RM_UPWARD      = 2'd2,
      RM_NEAREST     = 2'd3
   } round_mode_type;

   typedef struct packed {
      logic                  neg;
      logic                  invalid;
      round_mode_type        mode;
      logic [SIG_WIDTH-1:0]  sig;
      logic [EXP_WIDTH-1:0]  exp_eff;
   } unpack_type;

   typedef struct packed {
      logic                   neg;
      logic                   invalid;
      round_mode_type         mode;
      logic [WHOLE_WIDTH-1:0] whole;
      logic                   round_bit;
      logic                   sticky;
   } align_type;

   typedef struct packed {
      logic                 neg;
      logic                 invalid;
      logic [MAG_WIDTH-1:0] mag;
   } round_type;

endpackage

`default_nettype wire

FILE: rtl/hfti_unpack.sv
`default_nettype none

module hfti_unpack
   import hfti_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [HALF_WIDTH-1:0] in_half,
   input  wire round_mode_type        in_mode,
   output logic                       out_valid,
   output unpack_type                 out_data
);

   logic       valid_ff;
   unpack_type data_ff;
   unpack_type data_in;
   logic [EXP_WIDTH-1:0] exp_field;

   always_comb begin
      exp_field       = in_half[HALF_WIDTH-2 -: EXP_WIDTH];
      data_in.neg     = in_half[HALF_WIDTH-1];
      data_in.invalid = (exp_field == EXP_ALL_ONES);
      data_in.mode    = in_mode;
      if (exp_field == '0) begin
         // subnormal: no hidden bit, same scale as exponent 1
         data_in.sig     = {1'b0, in_half[FRAC_WIDTH-1:0]};
         data_in.exp_eff = EXP_SUBNORMAL;
      end else begin
         data_in.sig     = {1'b1, in_half[FRAC_WIDTH-1:0]};
         data_in.exp_eff = exp_field;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: rtl/hfti_align.sv
`default_nettype none

module hfti_align
   import hfti_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire unpack_type in_data,
   output logic            out_valid,
   output align_type       out_data
);

   logic                   valid_ff;
   align_type              data_ff;
   align_type              data_in;
   logic [ALIGN_WIDTH-1:0] shifted;

   always_comb begin
      // sig * 2^exp_eff; binary point sits at bit POINT
      shifted = {{(ALIGN_WIDTH-SIG_WIDTH){1'b0}}, in_data.sig} << in_data.exp_eff;
      data_in.neg       = in_data.neg;
      data_in.invalid   = in_data.invalid;
      data_in.mode      = in_data.mode;
      data_in.whole     = shifted[ALIGN_WIDTH-1:POINT];
      data_in.round_bit = shifted[POINT-1];
      data_in.sticky    = |shifted[POINT-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: rtl/hfti_round.sv
`default_nettype none

module hfti_round
   import hfti_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   input  wire align_type in_data,
   output logic           out_valid,
   output round_type      out_data
);

   logic      valid_ff;
   round_type data_ff;
   round_type data_in;
   logic      inexact;
   logic      bump;

   always_comb begin
      inexact = in_data.round_bit | in_data.sticky;
      unique case (in_data.mode)
         RM_TOWARD_ZERO: bump = 1'b0;
         RM_DOWNWARD:    bump = in_data.neg & inexact;
         RM_UPWARD:      bump = ~in_data.neg & inexact;
         RM_NEAREST:     bump = in_data.round_bit & (in_data.sticky | in_data.whole[0]);
         default:        bump = 1'b0;
      endcase
      data_in.neg     = in_data.neg;
      data_in.invalid = in_data.invalid;
      data_in.mag     = {1'b0, in_data.whole} + {{(MAG_WIDTH-1){1'b0}}, bump};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: rtl/half_float_to_integer_rounding.sv
// Throughput: one beat per cycle; four register stages (unpack, align, round,
//   sign/output), each stage takes a new beat every cycle.
// busy is always low and the receiver cannot stall; rsp_* hold a result for one cycle.
// Reset (synchronous, active high) clears all stage valid bits and sets
//   round_mode to nearest, ties to even.
`default_nettype none

module half_float_to_integer_rounding
   import hfti_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [HALF_WIDTH-1:0] req_half_bits,
   // result channel
   output logic                       rsp_valid,
   output logic signed [INT_WIDTH-1:0] rsp_int_value,
   output logic                       rsp_invalid,
   // control register write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_round_mode
);

   // rounding mode register; the user must write it only while the pipe is empty, the block does not enforce this
   round_mode_type mode_ff;

   logic       accept;
   logic       unpack_valid;
   unpack_type unpack_data;
   logic       align_valid;
   align_type  align_data;
   logic       round_valid;
   round_type  round_data;

   logic                 rsp_valid_ff;
   logic [INT_WIDTH-1:0] rsp_value_ff;
   logic [INT_WIDTH-1:0] rsp_value_in;
   logic                 rsp_invalid_ff;
   logic [INT_WIDTH-1:0] mag_ext;

   // pipe never backs up: no output stall exists
   assign busy      = 1'b0;
   assign accept    = start & ~busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= RM_NEAREST;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= round_mode_type'(csr_round_mode);
      end
   end

   // stage 1: split fields, flag inf/NaN, restore hidden bit; mode rides along
   hfti_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_half   (req_half_bits),
      .in_mode   (mode_ff),
      .out_valid (unpack_valid),
      .out_data  (unpack_data)
   );

   // stage 2: shift significand into fixed point, extract round and sticky
   hfti_align u_align (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (unpack_valid),
      .in_data   (unpack_data),
      .out_valid (align_valid),
      .out_data  (align_data)
   );

   // stage 3: increment decision per mode, magnitude add
   hfti_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (align_valid),
      .in_data   (align_data),
      .out_valid (round_valid),
      .out_data  (round_data)
   );

   // stage 4: apply sign (zero magnitude negates to zero), inf/NaN override
   always_comb begin
      mag_ext = {{(INT_WIDTH-MAG_WIDTH){1'b0}}, round_data.mag};
      if (round_data.invalid) begin
         rsp_value_in = INVALID_RESULT;
      end else if (round_data.neg) begin
         rsp_value_in = '0 - mag_ext;
      end else begin
         rsp_value_in = mag_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= round_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff   <= rsp_value_in;
      rsp_invalid_ff <= round_data.invalid;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_int_value = rsp_value_ff;
   assign rsp_invalid   = rsp_invalid_ff;

endmodule

`default_nettype wire

FILE: rtl/hfti_checker.sv
`default_nettype none

module hfti_checker
   import hfti_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic [HALF_WIDTH-1:0]  req_half_bits,
   input wire logic                   rsp_valid,
   input wire logic signed [INT_WIDTH-1:0] rsp_int_value,
   input wire logic                   rsp_invalid
);

   // every accepted beat yields exactly one result on rsp_valid
   a_beat_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted beat produced no result");

   a_result_from_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, 4))
      else $error("result without matching beat");

   a_invalid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_invalid == ($past(req_half_bits[14:10], 4) == EXP_ALL_ONES)))
      else $error("invalid flag does not match input exponent");

   a_invalid_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_int_value == INVALID_RESULT))
      else $error("inf/NaN result value wrong");

   a_finite_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_invalid) |->
         (rsp_int_value <= 32'sd65504 && rsp_int_value >= -32'sd65504))
      else $error("finite result out of binary16 range");

endmodule

bind half_float_to_integer_rounding hfti_checker u_hfti_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_half_bits (req_half_bits),
   .rsp_valid     (rsp_valid),
   .rsp_int_value (rsp_int_value),
   .rsp_invalid   (rsp_invalid)
);

`default_nettype wire
